>>> src/pdh_pkg.sv
// ============================================================================
// pdh_pkg: shared types and constants for the partition distance block
// Field widths, the controller state type, the datapath operation codes and
// the command and status bundles that join controller and datapath.
// ============================================================================
package pdh_pkg;

	localparam int LABEL_W = 8;
	localparam int DIST_W = 11;
	localparam int CLU_W = 9;

	localparam int DEF_MAX_CLUSTERS = 64;
	localparam int DEF_MAX_ELEMENTS = 1024;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_LOAD, ST_CHECK, ST_INIT, ST_RSET, ST_CK, ST_CK2, ST_T2, ST_T3,
		ST_SA, ST_SB, ST_UA, ST_UB, ST_UC, ST_UD, ST_NXT, ST_AA, ST_AB, ST_AC,
		ST_AD, ST_FIN, ST_FIN2, ST_OUT
	} pdh_state_t;

	typedef enum logic [4:0] {
		OP_IDLE, OP_CLEAR, OP_CHECK, OP_INIT, OP_RSET, OP_CK2, OP_T3, OP_SB,
		OP_UB, OP_UD, OP_NXT, OP_AB, OP_AD, OP_FIN2
	} pdh_op_t;

	typedef struct packed {
		pdh_op_t op;
		logic    in_ready;
		logic    out_valid;
	} pdh_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic idx_last;
		logic over;
		logic cm_nz;
		logic in_tree;
		logic at_root;
		logic row_last;
	} pdh_status_t;

endpackage

>>> src/pdh_pair_if.sv
// ============================================================================
// pdh_pair_if: element pair channel
// Carries one pair of cluster labels per transaction and the last marker.
// ============================================================================
interface pdh_pair_if import pdh_pkg::*;;
	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] label_a;
	logic [LABEL_W-1:0] label_b;
	logic               last;

	modport source(output valid, output label_a, output label_b, output last, input ready);
	modport sink(input valid, input label_a, input label_b, input last, output ready);
endinterface

>>> src/pdh_result_if.sv
// ============================================================================
// pdh_result_if: result channel
// Carries the partition distance, the cluster count and the overflow flag.
// ============================================================================
interface pdh_result_if import pdh_pkg::*;;
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic [CLU_W-1:0]  clusters_used;
	logic              overflow;

	modport source(output valid, output distance, output clusters_used, output overflow,
		input ready);
	modport sink(input valid, input distance, input clusters_used, input overflow,
		output ready);
endinterface

>>> src/partition_distance_hungarian.sv
// Pairs load one per cycle while the block is in its load phase. After the last
// pair a check runs; unless the set overflows, the solve runs init, then per row a
// reset pass and tree steps of column scan and potential update, then augmentation
// along the path columns. The matrix is n by n, n being the largest label plus one.
// One set is handled at a time. After reset and after every result a pass clears all
// 2^(2*ceil(log2 MAX_CLUSTERS)) overlap entries (4096 by default) before new pairs.
// ============================================================================
// partition_distance_hungarian: minimum partition distance
// Counts label pairs of two partitions and solves the assignment between
// their clusters with the Hungarian method to find the fewest elements that
// must be removed for the partitions to agree.
// ============================================================================
module partition_distance_hungarian import pdh_pkg::*; #(
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
	input logic          clk,
	input logic          arst_n,
	pdh_pair_if.sink     pairs,
	pdh_result_if.source result
);

	// The controller and datapath exchange only a command and a status bundle.
	pdh_cmd_t    cmd;
	pdh_status_t status;
	logic        pair_fire;
	logic        result_fire;

	// A pair transaction completes when both sides agree; pairs are taken
	// only while the controller is in its load phase.
	assign pairs.ready = cmd.in_ready;
	assign pair_fire = pairs.valid && pairs.ready;
	assign result.valid = cmd.out_valid;
	assign result_fire = result.valid && result.ready;

	pdh_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.last_fire   (pair_fire && pairs.last),
		.result_fire (result_fire),
		.status      (status),
		.cmd         (cmd)
	);

	// The datapath holds the counters, the solver scratch memories and the
	// result registers, which stay stable while the result is offered.
	pdh_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.in_fire       (pair_fire),
		.label_a       (pairs.label_a),
		.label_b       (pairs.label_b),
		.distance      (result.distance),
		.clusters_used (result.clusters_used),
		.overflow      (result.overflow)
	);

	// The last pair closes the load phase at once.
	a_last_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		pair_fire && pairs.last |=> !pairs.ready)
		else $error("pairs still taken after the last pair");
	// No pair is taken while a result waits.
	a_result_blocks_load: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !pairs.ready)
		else $error("pair taken while a result is pending");
	// An overflowing answer reports zero distance.
	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.overflow |-> result.distance == '0)
		else $error("overflow result with nonzero distance");

endmodule

>>> src/pdh_datapath.sv
// ============================================================================
// pdh_datapath: load counters and Hungarian solver datapath
// Holds the overlap and label count memories with their increment pipeline,
// the solver scratch memories, and the index and potential registers.
// ============================================================================
module pdh_datapath import pdh_pkg::*; #(
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pdh_cmd_t           cmd,
	output pdh_status_t        status,
	input  logic               in_fire,
	input  logic [LABEL_W-1:0] label_a,
	input  logic [LABEL_W-1:0] label_b,
	output logic [DIST_W-1:0]  distance,
	output logic [CLU_W-1:0]   clusters_used,
	output logic               overflow
);

	localparam int A_W = $clog2(MAX_CLUSTERS);
	localparam int OV_DEPTH = 1 << (2 * A_W);
	localparam int LC_DEPTH = 1 << A_W;
	localparam int CLR_W = 2 * A_W;
	localparam int D = MAX_CLUSTERS + 1;
	localparam int IDX_W = $clog2(D);
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int EL_W = $clog2(MAX_ELEMENTS + 2);
	localparam int COST_W = CNT_W + 1;
	localparam int POT_W = COST_W + A_W + 2;
	localparam logic signed [POT_W-1:0] BIG = {1'b0, {(POT_W-1){1'b1}}};

	// Load stores.
	logic [CNT_W-1:0] ov_mem [OV_DEPTH];
	logic [CNT_W-1:0] lc_mem [LC_DEPTH];
	logic [CNT_W-1:0] ov_rd_q, lc_rd_q;
	logic [CLR_W-1:0] ov_raddr, ov_waddr, ld_ov_addr_s1, wb_ov_addr_q;
	logic [A_W-1:0]   lc_raddr, lc_waddr, ld_lc_addr_s1, wb_lc_addr_q;
	logic [CNT_W-1:0] ov_wd, lc_wd, wb_ov_q, wb_lc_q;
	logic             ov_we, lc_we, ld_v_s1, wb_v_q;
	logic [CLR_W-1:0] clr_q;

	// Load summary.
	logic [LABEL_W-1:0] max_q, max_new;
	logic [EL_W-1:0]    elem_q, elem_new;
	logic [CLU_W-1:0]   n_q, n_new;
	logic               over_q, count_ok;
	logic [DIST_W-1:0]  dist_q;

	// Solver scratch.
	logic signed [POT_W-1:0] cp_mem [D];
	logic signed [POT_W-1:0] sl_mem [D];
	logic signed [POT_W-1:0] rp_mem [D];
	logic [IDX_W-1:0]        pa_mem [D];
	logic [IDX_W-1:0]        cm_mem [D];
	logic                    it_mem [D];
	logic signed [POT_W-1:0] cp_rd_q, sl_rd_q, rp_rd_q;
	logic [IDX_W-1:0]        pa_rd_q, cm_rd_q;
	logic                    it_rd_q;
	logic signed [POT_W-1:0] cp_wd, sl_wd, rp_wd;
	logic [IDX_W-1:0]        pa_wd, cm_wd, cm_wa, rp_wa;
	logic                    cp_we, sl_we, pa_we, cm_we, it_we, it_wd, rp_we;

	logic [IDX_W-1:0]        idx_q, i_q, j0_q, j1_q, row_q, i0_q, idx_next;
	logic signed [POT_W-1:0] u0_q, delta_q;
	logic                    dfirst_q;
	logic signed [COST_W-1:0] cost;
	logic signed [POT_W-1:0]  cur, smin;

	// Load front end.
	always_comb begin
		max_new = max_q;
		if (label_a > max_new) max_new = label_a;
		if (label_b > max_new) max_new = label_b;
		elem_new = (elem_q <= EL_W'(MAX_ELEMENTS)) ? elem_q + 1'b1 : elem_q;
		n_new = CLU_W'(max_new) + 1'b1;
		count_ok = (elem_q < EL_W'(MAX_ELEMENTS))
			&& ({1'b0, label_a} < CLU_W'(MAX_CLUSTERS))
			&& ({1'b0, label_b} < CLU_W'(MAX_CLUSTERS));
	end

	assign ov_raddr = cmd.in_ready ? {label_a[A_W-1:0], label_b[A_W-1:0]}
		: {A_W'(idx_q - 1'b1), A_W'(i0_q - 1'b1)};
	assign lc_raddr = cmd.in_ready ? label_a[A_W-1:0] : A_W'(idx_q - 1'b1);

	// Read-modify-write with a one-deep bypass for back-to-back hits.
	always_comb begin
		ov_we = 1'b0;
		lc_we = 1'b0;
		ov_waddr = ld_ov_addr_s1;
		lc_waddr = ld_lc_addr_s1;
		ov_wd = ((wb_v_q && wb_ov_addr_q == ld_ov_addr_s1) ? wb_ov_q : ov_rd_q) + 1'b1;
		lc_wd = ((wb_v_q && wb_lc_addr_q == ld_lc_addr_s1) ? wb_lc_q : lc_rd_q) + 1'b1;
		if (cmd.op == OP_CLEAR) begin
			ov_we = 1'b1;
			ov_waddr = clr_q;
			ov_wd = '0;
			lc_we = (clr_q[CLR_W-1:A_W] == '0);
			lc_waddr = clr_q[A_W-1:0];
			lc_wd = '0;
		end else if (ld_v_s1) begin
			ov_we = 1'b1;
			lc_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ov_we) ov_mem[ov_waddr] <= ov_wd;
		if (lc_we) lc_mem[lc_waddr] <= lc_wd;
		ov_rd_q <= ov_mem[ov_raddr];
		lc_rd_q <= lc_mem[lc_raddr];
		ld_ov_addr_s1 <= {label_a[A_W-1:0], label_b[A_W-1:0]};
		ld_lc_addr_s1 <= label_a[A_W-1:0];
		wb_ov_addr_q <= ld_ov_addr_s1;
		wb_lc_addr_q <= ld_lc_addr_s1;
		wb_ov_q <= ov_wd;
		wb_lc_q <= lc_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1 <= 1'b0;
			wb_v_q <= 1'b0;
		end else begin
			ld_v_s1 <= in_fire && count_ok;
			wb_v_q <= ld_v_s1 && cmd.op != OP_CLEAR;
		end
	end

	// Solver arithmetic.
	always_comb begin
		cost = $signed({1'b0, lc_rd_q}) - $signed({1'b0, ov_rd_q});
		cur = POT_W'(cost) - u0_q - cp_rd_q;
		smin = (cur < sl_rd_q) ? cur : sl_rd_q;
		idx_next = status.idx_last ? '0 : idx_q + 1'b1;
	end

	always_comb begin
		cp_we = 1'b0; cp_wd = '0;
		sl_we = 1'b0; sl_wd = BIG;
		pa_we = 1'b0; pa_wd = '0;
		cm_we = 1'b0; cm_wa = idx_q; cm_wd = '0;
		it_we = 1'b0; it_wd = 1'b0;
		rp_we = 1'b0; rp_wa = idx_q; rp_wd = '0;
		case (cmd.op)
			OP_INIT: begin
				cp_we = 1'b1;
				pa_we = 1'b1;
				cm_we = 1'b1;
				rp_we = 1'b1;
			end
			OP_RSET: begin
				sl_we = 1'b1;
				it_we = 1'b1;
				if (idx_q == '0) begin
					cm_we = 1'b1;
					cm_wd = i_q;
				end
			end
			OP_CK2: begin
				if (cm_rd_q != '0) begin
					it_we = 1'b1;
					it_wd = 1'b1;
				end
			end
			OP_SB: begin
				if (!it_rd_q && cur < sl_rd_q) begin
					sl_we = 1'b1;
					sl_wd = cur;
					pa_we = 1'b1;
					pa_wd = j0_q;
				end
			end
			OP_UB: begin
				if (it_rd_q) begin
					cp_we = 1'b1;
					cp_wd = cp_rd_q - delta_q;
				end else begin
					sl_we = 1'b1;
					sl_wd = sl_rd_q - delta_q;
				end
			end
			OP_UD: begin
				rp_we = 1'b1;
				rp_wa = row_q;
				rp_wd = rp_rd_q + delta_q;
			end
			OP_AD: begin
				cm_we = 1'b1;
				cm_wa = j0_q;
				cm_wd = cm_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cp_we) cp_mem[idx_q] <= cp_wd;
		if (sl_we) sl_mem[idx_q] <= sl_wd;
		if (pa_we) pa_mem[idx_q] <= pa_wd;
		if (it_we) it_mem[idx_q] <= it_wd;
		if (cm_we) cm_mem[cm_wa] <= cm_wd;
		if (rp_we) rp_mem[rp_wa] <= rp_wd;
		cp_rd_q <= cp_mem[idx_q];
		sl_rd_q <= sl_mem[idx_q];
		pa_rd_q <= pa_mem[idx_q];
		it_rd_q <= it_mem[idx_q];
		cm_rd_q <= cm_mem[idx_q];
		rp_rd_q <= rp_mem[row_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			max_q <= '0;
			elem_q <= '0;
			n_q <= CLU_W'(1);
			over_q <= 1'b0;
			idx_q <= '0;
			i_q <= '0;
			j0_q <= '0;
			j1_q <= '0;
			row_q <= '0;
			i0_q <= '0;
			dfirst_q <= 1'b0;
		end else begin
			if (in_fire) begin
				max_q <= max_new;
				elem_q <= elem_new;
				n_q <= n_new;
				over_q <= (n_new > CLU_W'(MAX_CLUSTERS)) || (elem_new > EL_W'(MAX_ELEMENTS));
			end
			case (cmd.op)
				OP_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					max_q <= '0;
					elem_q <= '0;
				end
				OP_CHECK: idx_q <= '0;
				OP_INIT: begin
					idx_q <= idx_next;
					if (status.idx_last) i_q <= IDX_W'(1);
				end
				OP_RSET: idx_q <= idx_next;
				OP_CK2: begin
					j0_q <= idx_q;
					i0_q <= cm_rd_q;
					row_q <= cm_rd_q;
				end
				OP_T3: begin
					dfirst_q <= 1'b1;
					idx_q <= IDX_W'(1);
				end
				OP_SB: begin
					if (!it_rd_q && (dfirst_q || smin < delta_q)) begin
						dfirst_q <= 1'b0;
						j1_q <= idx_q;
					end
					idx_q <= idx_next;
				end
				OP_UB: begin
					if (it_rd_q) row_q <= cm_rd_q;
					else idx_q <= idx_next;
				end
				OP_UD: idx_q <= idx_next;
				OP_NXT: begin
					j0_q <= j1_q;
					idx_q <= j1_q;
				end
				OP_AB: idx_q <= pa_rd_q;
				OP_AD: begin
					j0_q <= idx_q;
					if (idx_q == '0 && !status.row_last) i_q <= i_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Potential and result registers carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_T3) u0_q <= rp_rd_q;
		if (cmd.op == OP_SB && !it_rd_q && (dfirst_q || smin < delta_q)) delta_q <= smin;
		if (cmd.op == OP_CHECK) dist_q <= '0;
		if (cmd.op == OP_FIN2) dist_q <= DIST_W'(-cp_rd_q);
	end

	always_comb begin
		status.clear_done = &clr_q;
		status.idx_last = (CLU_W'(idx_q) == n_q);
		status.over = over_q;
		status.cm_nz = (cm_rd_q != '0);
		status.in_tree = it_rd_q;
		status.at_root = (idx_q == '0);
		status.row_last = (CLU_W'(i_q) == n_q);
	end

	assign distance = dist_q;
	assign clusters_used = n_q;
	assign overflow = over_q;

	a_no_load_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_CLEAR |-> !ld_v_s1)
		else $error("load write collides with clearing pass");
	a_tree_root_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_T3 |-> i0_q != '0)
		else $error("tree grown from an empty column");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_SB |-> idx_q != '0 && CLU_W'(idx_q) <= n_q)
		else $error("column scan out of range");

endmodule

>>> src/pdh_ctrl.sv
// ============================================================================
// pdh_ctrl: sequencer for load, clear and Hungarian solve
// Steps through clearing, loading, potential init, tree growth, potential
// update and augmentation, and issues one datapath operation per cycle.
// ============================================================================
module pdh_ctrl import pdh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        last_fire,
	input  logic        result_fire,
	input  pdh_status_t status,
	output pdh_cmd_t    cmd
);

	pdh_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (status.clear_done) state_d = ST_LOAD;
			ST_LOAD:  if (last_fire) state_d = ST_CHECK;
			ST_CHECK: state_d = status.over ? ST_OUT : ST_INIT;
			ST_INIT:  if (status.idx_last) state_d = ST_RSET;
			ST_RSET:  if (status.idx_last) state_d = ST_CK;
			ST_CK:    state_d = ST_CK2;
			ST_CK2:   state_d = status.cm_nz ? ST_T2 : ST_AA;
			ST_T2:    state_d = ST_T3;
			ST_T3:    state_d = ST_SA;
			ST_SA:    state_d = ST_SB;
			ST_SB:    state_d = status.idx_last ? ST_UA : ST_SA;
			ST_UA:    state_d = ST_UB;
			ST_UB: begin
				if (status.in_tree) state_d = ST_UC;
				else state_d = status.idx_last ? ST_NXT : ST_UA;
			end
			ST_UC:    state_d = ST_UD;
			ST_UD:    state_d = status.idx_last ? ST_NXT : ST_UA;
			ST_NXT:   state_d = ST_CK;
			ST_AA:    state_d = ST_AB;
			ST_AB:    state_d = ST_AC;
			ST_AC:    state_d = ST_AD;
			ST_AD: begin
				if (!status.at_root) state_d = ST_AA;
				else state_d = status.row_last ? ST_FIN : ST_RSET;
			end
			ST_FIN:   state_d = ST_FIN2;
			ST_FIN2:  state_d = ST_OUT;
			ST_OUT:   if (result_fire) state_d = ST_CLEAR;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd.op = OP_IDLE;
		cmd.in_ready = 1'b0;
		cmd.out_valid = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.op = OP_CLEAR;
			ST_LOAD:  cmd.in_ready = 1'b1;
			ST_CHECK: cmd.op = OP_CHECK;
			ST_INIT:  cmd.op = OP_INIT;
			ST_RSET:  cmd.op = OP_RSET;
			ST_CK2:   cmd.op = OP_CK2;
			ST_T3:    cmd.op = OP_T3;
			ST_SB:    cmd.op = OP_SB;
			ST_UB:    cmd.op = OP_UB;
			ST_UD:    cmd.op = OP_UD;
			ST_NXT:   cmd.op = OP_NXT;
			ST_AB:    cmd.op = OP_AB;
			ST_AD:    cmd.op = OP_AD;
			ST_FIN2:  cmd.op = OP_FIN2;
			ST_OUT:   cmd.out_valid = 1'b1;
			default:  cmd.op = OP_IDLE;
		endcase
	end

endmodule

>>> bench/tb_top.sv
// ============================================================================
// tb_top: testbench for the partition distance block
// Streams sets of label pairs, each closed by a last marker, into the block.
// A scoreboard class keeps its own pair counts and solves the assignment
// itself, then checks every distance transaction field by field. Sender
// gaps and receiver stalls vary over several phases.
// ============================================================================
module tb_top;
	import pdh_pkg::*;

	localparam int NCLU = DEF_MAX_CLUSTERS;
	localparam int NELEM = DEF_MAX_ELEMENTS;
	localparam int CYCLE_LIMIT = 8000000;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic [CLU_W-1:0]  clusters_used;
		logic              overflow;
	} answer_t;

	// The scoreboard mirrors the load stores of the block and keeps the
	// answers that the block still owes, oldest first.
	class distance_scoreboard;
		int unsigned overlap[NCLU][NCLU];
		int unsigned label_cnt[NCLU];
		int unsigned elem_cnt;
		int unsigned max_lbl;
		answer_t     owed[$];
		int          errors;

		function void clear_sets();
			foreach (overlap[x, y]) overlap[x][y] = 0;
			foreach (label_cnt[x]) label_cnt[x] = 0;
			elem_cnt = 0;
			max_lbl = 0;
		endfunction

		function new();
			clear_sets();
			errors = 0;
		endfunction

		function longint cost(int r, int c);
			return longint'(label_cnt[c-1]) - longint'(overlap[c-1][r-1]);
		endfunction

		// Hungarian method on an n by n matrix, rows and columns 1-based.
		function int unsigned assign_cost(int n);
			longint rp[0:NCLU], cp[0:NCLU], slack[0:NCLU];
			int     cm[0:NCLU], par[0:NCLU];
			bit     seen[0:NCLU];
			int     i, j, j0, j1, i0;
			longint delta, cur, total;
			longint big;
			big = longint'(1) << 40;
			total = 0;
			for (j = 0; j <= n; j++) begin
				rp[j] = 0;
				cp[j] = 0;
				cm[j] = 0;
				par[j] = 0;
			end
			for (i = 1; i <= n; i++) begin
				cm[0] = i;
				j0 = 0;
				for (j = 0; j <= n; j++) begin
					slack[j] = big;
					seen[j] = 0;
				end
				do begin
					seen[j0] = 1;
					i0 = cm[j0];
					delta = big;
					j1 = 0;
					for (j = 1; j <= n; j++) begin
						if (!seen[j]) begin
							cur = cost(i0, j) - rp[i0] - cp[j];
							if (cur < slack[j]) begin
								slack[j] = cur;
								par[j] = j0;
							end
							if (slack[j] < delta) begin
								delta = slack[j];
								j1 = j;
							end
						end
					end
					for (j = 0; j <= n; j++) begin
						if (seen[j]) begin
							rp[cm[j]] += delta;
							cp[j] -= delta;
						end else begin
							slack[j] -= delta;
						end
					end
					j0 = j1;
				end while (cm[j0] != 0);
				do begin
					j1 = par[j0];
					cm[j0] = cm[j1];
					j0 = j1;
				end while (j0 != 0);
			end
			for (j = 1; j <= n; j++) total += cost(cm[j], j);
			return int'(total);
		endfunction

		// Notes one accepted pair transaction.
		function void note_pair(int unsigned a, int unsigned b, bit last);
			answer_t     ans;
			int unsigned n;
			bit          over;
			if (a > max_lbl) max_lbl = a;
			if (b > max_lbl) max_lbl = b;
			if (elem_cnt <= NELEM) elem_cnt++;
			if (elem_cnt <= NELEM && a < NCLU && b < NCLU) begin
				label_cnt[a]++;
				overlap[a][b]++;
			end
			if (last) begin
				n = max_lbl + 1;
				over = (n > NCLU) || (elem_cnt > NELEM);
				ans.distance = over ? '0 : DIST_W'(assign_cost(n));
				ans.clusters_used = CLU_W'(n);
				ans.overflow = over;
				owed.push_back(ans);
				clear_sets();
			end
		endfunction

		// Checks one accepted result transaction against the oldest answer.
		function void check_result(logic [DIST_W-1:0] d, logic [CLU_W-1:0] c, logic o);
			answer_t ans;
			if (owed.size() == 0) begin
				$error("result with no answer owed: distance %0d", d);
				errors++;
				return;
			end
			ans = owed.pop_front();
			if (d !== ans.distance) begin
				$error("distance: expected %0d, got %0d", ans.distance, d);
				errors++;
			end
			if (c !== ans.clusters_used) begin
				$error("clusters_used: expected %0d, got %0d", ans.clusters_used, c);
				errors++;
			end
			if (o !== ans.overflow) begin
				$error("overflow: expected %0d, got %0d", ans.overflow, o);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycle = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   sent = 0;

	distance_scoreboard sb = new();

	pdh_pair_if   pairs_if();
	pdh_result_if res_if();

	partition_distance_hungarian dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pairs (pairs_if.sink),
		.result(res_if.source)
	);

	always #4 clk = ~clk;

	// Global watchdog on the cycle count.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Receiver: the ready level changes at the falling edge, and results are
	// taken at the rising edge when valid and ready are both high.
	initial res_if.ready = 1'b0;
	always @(negedge clk) res_if.ready <= ($urandom_range(99) >= stall_pct);
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result(res_if.distance, res_if.clusters_used, res_if.overflow);
	end

	// Sends one pair. Called at a falling edge and returns at a falling edge,
	// so valid stays high across back-to-back transactions.
	task automatic send_pair(int unsigned a, int unsigned b, bit last);
		while ($urandom_range(99) < idle_pct) begin
			pairs_if.valid <= 1'b0;
			@(negedge clk);
		end
		pairs_if.valid <= 1'b1;
		pairs_if.label_a <= LABEL_W'(a);
		pairs_if.label_b <= LABEL_W'(b);
		pairs_if.last <= last;
		@(posedge clk);
		while (!pairs_if.ready) @(posedge clk);
		sb.note_pair(a, b, last);
		sent++;
		@(negedge clk);
	endtask

	// Sends a whole set with labels drawn from 0..top.
	task automatic send_set(int len, int unsigned top);
		for (int k = 0; k < len; k++)
			send_pair($urandom_range(top), $urandom_range(top), k == len - 1);
	endtask

	// Random sets: mostly few clusters, sometimes wider ones, and now and
	// then labels past the cluster limit.
	task automatic random_sets(int count);
		int target;
		int pick;
		target = sent + count;
		while (sent < target) begin
			pick = $urandom_range(99);
			if (pick < 80) send_set($urandom_range(1, 12), $urandom_range(0, 7));
			else if (pick < 92) send_set($urandom_range(4, 30), $urandom_range(8, 20));
			else send_set($urandom_range(1, 6), 255);
		end
	endtask

	initial begin
		pairs_if.valid = 1'b0;
		pairs_if.label_a = '0;
		pairs_if.label_b = '0;
		pairs_if.last = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed sets: a single element, identical and crossed partitions,
		// the widest legal label, and labels past the cluster limit.
		send_pair(0, 0, 1);
		send_pair(1, 0, 0);
		send_pair(0, 1, 1);
		for (int k = 0; k < 4; k++) send_pair(k, k, k == 3);
		for (int k = 0; k < 4; k++) send_pair(k, 3 - k, k == 3);
		send_pair(0, 0, 0);
		send_pair(0, 1, 0);
		send_pair(1, 1, 0);
		send_pair(2, 0, 1);
		send_pair(63, 63, 1);
		send_pair(64, 0, 1);
		send_pair(0, 255, 1);
		send_pair(255, 128, 1);

		// Element count at the limit, and three past it.
		for (int k = 0; k < NELEM; k++)
			send_pair($urandom_range(3), $urandom_range(3), k == NELEM - 1);
		for (int k = 0; k < NELEM + 3; k++)
			send_pair($urandom_range(3), $urandom_range(3), k == NELEM + 2);

		idle_pct = 0;
		stall_pct = 0;
		random_sets(125);
		idle_pct = 72;
		stall_pct = 0;
		random_sets(125);
		idle_pct = 0;
		stall_pct = 72;
		random_sets(125);
		idle_pct = 24;
		stall_pct = 24;
		random_sets(125);

		pairs_if.valid <= 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (5000) @(negedge clk);

		if (sb.errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule

>>> files.f
src/pdh_pkg.sv
src/pdh_pair_if.sv
src/pdh_result_if.sv
src/pdh_datapath.sv
src/pdh_ctrl.sv
src/partition_distance_hungarian.sv
bench/tb_top.sv
